// ===== rtl/fcr_pkg.sv =====
// ----------------------------------------------------------------------------
// fcr_pkg
// Shared constants, reply job type and back-end state type for the framed
// command responder.
// ----------------------------------------------------------------------------
package fcr_pkg;

  // Frame bytes
  localparam logic [7:0] HDR0        = 8'hAA;
  localparam logic [7:0] HDR1        = 8'hAB;
  localparam logic [7:0] CMD_CHECK   = 8'h01;
  localparam logic [7:0] CMD_TEMP    = 8'h02;
  localparam logic [7:0] FILL_BYTE   = 8'hCC;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] LEN_CHECK   = 8'd2;
  localparam logic [7:0] LEN_TEMP    = 8'd4;

  // Byte counter saturates here
  localparam logic [5:0] COUNT_TOP = 6'd63;

  // Temperature clamp range, tenths of a degree
  localparam logic signed [14:0] TEMP_MIN = -15'sd999;
  localparam logic signed [14:0] TEMP_MAX = 15'sd9999;

  // Defaults for top-level parameters
  localparam int MAX_PACKET_BYTES_DEF = 32;
  localparam int JOBQ_DEPTH_DEF       = 4;

  // One reply to be sent: kind, sign and clamped magnitude
  typedef struct packed {
    logic        is_temp;
    logic        neg;
    logic [13:0] mag;
  } job_t;

  // Back-end sequencer state
  typedef enum logic {
    BK_IDLE,
    BK_SEND
  } back_state_t;

endpackage

// ===== rtl/fcr_front.sv =====
// ----------------------------------------------------------------------------
// fcr_front
// Packet parser: tracks header, command, length and running checksum over
// the received words and queues a reply job at the last word of a good frame.
// ----------------------------------------------------------------------------
module fcr_front import fcr_pkg::*; #(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_packet_end,
  input  logic signed [14:0] in_temperature,
  input  logic               q_full,
  output logic               q_push,
  output job_t               q_job
);

  localparam logic [5:0] MAX_BYTES = 6'(MAX_PACKET_BYTES);

  logic [5:0] cnt_r, cnt_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       hdr_good_r, hdr_good_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] len_r, len_nxt;
  logic       ck_good_r, ck_good_nxt;
  logic       ck_seen_r, ck_seen_nxt;
  logic       overlong_r, overlong_nxt;
  logic       accept;
  logic       verdict;
  logic signed [14:0] temp_clamp;
  logic [14:0] temp_abs;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // Per-word parse update
  always_comb begin
    hdr_good_nxt = hdr_good_r;
    cmd_nxt      = cmd_r;
    len_nxt      = len_r;
    ck_good_nxt  = ck_good_r;
    ck_seen_nxt  = ck_seen_r;
    overlong_nxt = overlong_r || (cnt_r >= MAX_BYTES);
    if (cnt_r == 6'd0) begin
      if (in_rx_byte != HDR0) hdr_good_nxt = 1'b0;
    end else if (cnt_r == 6'd1) begin
      if (in_rx_byte != HDR1) hdr_good_nxt = 1'b0;
    end else if (cnt_r == 6'd2) begin
      cmd_nxt = in_rx_byte;
    end else if (cnt_r == 6'd3) begin
      len_nxt = in_rx_byte;
    end else if (!ck_seen_r && ({3'b000, cnt_r} == {1'b0, len_r} + 9'd4)) begin
      ck_good_nxt = (in_rx_byte == sum_r);
      ck_seen_nxt = 1'b1;
    end
    // checksum word itself and anything after it stay out of the sum
    sum_nxt = ck_seen_nxt ? sum_r : sum_r + in_rx_byte;
    cnt_nxt = (cnt_r < COUNT_TOP) ? cnt_r + 6'd1 : cnt_r;
  end

  // Frame verdict at the last word
  assign verdict = hdr_good_nxt && ck_seen_nxt && ck_good_nxt && !overlong_nxt &&
                   ((cmd_nxt == CMD_CHECK) || (cmd_nxt == CMD_TEMP));

  // Clamp and split temperature into sign and magnitude
  always_comb begin
    if (in_temperature < TEMP_MIN) begin
      temp_clamp = TEMP_MIN;
    end else if (in_temperature > TEMP_MAX) begin
      temp_clamp = TEMP_MAX;
    end else begin
      temp_clamp = in_temperature;
    end
    temp_abs = temp_clamp[14] ? 15'(-temp_clamp) : 15'(temp_clamp);
  end

  assign q_push      = accept && in_packet_end && verdict;
  assign q_job.is_temp = (cmd_nxt == CMD_TEMP);
  assign q_job.neg     = temp_clamp[14];
  assign q_job.mag     = temp_abs[13:0];

  // Parse state; cleared after every last word
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_packet_end)) begin
      cnt_r      <= '0;
      sum_r      <= '0;
      hdr_good_r <= 1'b1;
      cmd_r      <= '0;
      len_r      <= '0;
      ck_good_r  <= 1'b0;
      ck_seen_r  <= 1'b0;
      overlong_r <= 1'b0;
    end else if (accept) begin
      cnt_r      <= cnt_nxt;
      sum_r      <= sum_nxt;
      hdr_good_r <= hdr_good_nxt;
      cmd_r      <= cmd_nxt;
      len_r      <= len_nxt;
      ck_good_r  <= ck_good_nxt;
      ck_seen_r  <= ck_seen_nxt;
      overlong_r <= overlong_nxt;
    end
  end

endmodule

// ===== rtl/fcr_jobq.sv =====
// ----------------------------------------------------------------------------
// fcr_jobq
// Small FIFO of reply jobs between parser and reply sequencer.
// ----------------------------------------------------------------------------
module fcr_jobq import fcr_pkg::*; #(
  parameter int DEPTH = JOBQ_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output job_t rd_job,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  job_t          slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = slots_r[rd_ptr_r];

  // Job storage
  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_ptr_r] <= wr_job;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/fcr_back.sv =====
// ----------------------------------------------------------------------------
// fcr_back
// Reply sequencer: takes one job, presents the reply frame word by word and
// accumulates its checksum. Temperature digits come from a double-dabble
// conversion that runs while the header words go out.
// ----------------------------------------------------------------------------
module fcr_back import fcr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  job_t       q_job,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_tx_byte,
  output logic       out_tx_last
);

  // Word positions within a reply
  localparam logic [3:0] POS_HDR0  = 4'd0;
  localparam logic [3:0] POS_HDR1  = 4'd1;
  localparam logic [3:0] POS_CMD   = 4'd2;
  localparam logic [3:0] POS_LEN   = 4'd3;
  localparam logic [3:0] POS_D0    = 4'd4;
  localparam logic [3:0] POS_D1    = 4'd5;
  localparam logic [3:0] POS_D2    = 4'd6;
  localparam logic [3:0] POS_D3    = 4'd7;
  localparam logic [3:0] LAST_CHK  = 4'd6;
  localparam logic [3:0] LAST_TEMP = 4'd8;
  localparam logic [2:0] CONV_STEPS = 3'd4;

  back_state_t state_r, state_nxt;
  logic        is_temp_r;
  logic        neg_r;
  logic [31:0] dd_r;       // {bcd, binary} shift register
  logic [2:0]  conv_r;
  logic [3:0]  pos_r;
  logic [7:0]  sum_r;
  logic [3:0]  last_pos;
  logic        conv_done;
  logic        word_ok;
  logic        take;
  logic        load;

  // Four double-dabble shifts per cycle
  function automatic logic [31:0] dd_step(input logic [31:0] v);
    logic [31:0] w;
    w = v;
    for (int s = 0; s < 4; s++) begin
      for (int d = 0; d < 4; d++) begin
        if (w[16 + 4*d +: 4] >= 4'd5) w[16 + 4*d +: 4] = w[16 + 4*d +: 4] + 4'd3;
      end
      w = {w[30:0], 1'b0};
    end
    return w;
  endfunction

  function automatic logic [7:0] ascii_digit(input logic [3:0] d);
    return ASCII_ZERO + {4'b0000, d};
  endfunction

  assign last_pos  = is_temp_r ? LAST_TEMP : LAST_CHK;
  assign conv_done = (conv_r == CONV_STEPS);
  assign out_tx_last = (pos_r == last_pos);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!q_empty) state_nxt = BK_SEND;
      BK_SEND: if (take && out_tx_last && q_empty) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Outputs: digit words wait for the conversion
  always_comb begin
    word_ok = 1'b0;
    unique case (state_r)
      BK_IDLE: word_ok = 1'b0;
      BK_SEND: word_ok = !(is_temp_r && (pos_r >= POS_D0) && !conv_done);
      default: word_ok = 1'b0;
    endcase
    out_empty = !word_ok;
    take      = word_ok && out_pop;
    load      = !q_empty && ((state_r == BK_IDLE) || (take && out_tx_last));
    q_pop     = load;
  end

  // Reply word select
  always_comb begin
    case (pos_r)
      POS_HDR0: out_tx_byte = HDR0;
      POS_HDR1: out_tx_byte = HDR1;
      POS_CMD:  out_tx_byte = is_temp_r ? CMD_TEMP : CMD_CHECK;
      POS_LEN:  out_tx_byte = is_temp_r ? LEN_TEMP : LEN_CHECK;
      POS_D0: begin
        if (!is_temp_r) begin
          out_tx_byte = FILL_BYTE;
        end else if (neg_r) begin
          out_tx_byte = ASCII_MINUS;
        end else begin
          out_tx_byte = ascii_digit(dd_r[31:28]);
        end
      end
      POS_D1:  out_tx_byte = is_temp_r ? ascii_digit(dd_r[27:24]) : FILL_BYTE;
      POS_D2:  out_tx_byte = is_temp_r ? ascii_digit(dd_r[23:20]) : sum_r;
      POS_D3:  out_tx_byte = ascii_digit(dd_r[19:16]);
      default: out_tx_byte = sum_r;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Job, position, checksum and conversion registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= '0;
      conv_r <= '0;
    end else if (load) begin
      is_temp_r <= q_job.is_temp;
      neg_r     <= q_job.neg;
      dd_r      <= {16'h0000, 2'b00, q_job.mag};
      conv_r    <= '0;
      pos_r     <= '0;
      sum_r     <= '0;
    end else begin
      if (state_r == BK_SEND && !conv_done) begin
        dd_r   <= dd_step(dd_r);
        conv_r <= conv_r + 3'd1;
      end
      if (take) begin
        pos_r <= pos_r + 4'd1;
        sum_r <= sum_r + out_tx_byte;
      end
    end
  end

endmodule

// ===== rtl/framed_command_responder_core.sv =====
// ----------------------------------------------------------------------------
// framed_command_responder_core
// Received packet parser with command reply generator.
// The reply job for a good packet is registered in the job queue; the sequencer then loads it and presents the reply.
// Throughput: one packet word per cycle in while the job queue has room;
// one reply word per cycle out while out_pop is held, a reply being 7 or 9 words.
// Reply jobs queue between parser and sequencer, so input stalls only when
// that queue is full. Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module framed_command_responder_core import fcr_pkg::*; #(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF,
  parameter int JOBQ_DEPTH       = JOBQ_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_packet_end,
  input  logic signed [14:0] in_temperature,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [7:0]         out_tx_byte,
  output logic               out_tx_last
);

  logic q_full, q_empty, q_push, q_pop;
  job_t wr_job, rd_job;

  // Parser
  fcr_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_rx_byte     (in_rx_byte),
    .in_packet_end  (in_packet_end),
    .in_temperature (in_temperature),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (wr_job)
  );

  // Reply job queue
  fcr_jobq #(
    .DEPTH(JOBQ_DEPTH)
  ) u_jobq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .rd_job (rd_job),
    .empty  (q_empty)
  );

  // Reply sequencer
  fcr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_job       (rd_job),
    .q_pop       (q_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_tx_byte (out_tx_byte),
    .out_tx_last (out_tx_last)
  );

`ifndef SYNTHESIS
  a_job_needs_last_word: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (in_push && !in_full && in_packet_end))
    else $error("reply job queued without an accepted last word");

  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("job queue both full and empty");

  a_pop_only_with_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job popped from empty queue");

  a_new_frame_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && out_tx_last) |=> (out_empty || out_tx_byte == HDR0))
    else $error("reply does not restart with header word");
`endif

endmodule
